// ----- rtl/fsq_pkg.sv -----
`timescale 1ns / 1ps
package fsq_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SORT_I,
		ST_SORT_KEY,
		ST_SORT_CHK,
		ST_SORT_CMP,
		ST_I_CHK,
		ST_I_GOT,
		ST_J_CHK,
		ST_J_GOT,
		ST_P_START,
		ST_P_A,
		ST_P_B,
		ST_EVAL,
		ST_MATCH,
		ST_LO_STEP,
		ST_LO_GOT,
		ST_HI_STEP,
		ST_HI_GOT,
		ST_JS_STEP,
		ST_JS_GOT,
		ST_IS_STEP,
		ST_IS_GOT,
		ST_PASS_END,
		ST_MARK
	} state_t;

	typedef enum logic {
		PASS_COUNT,
		PASS_EMIT
	} pass_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} alu_flag_t;

	localparam int VAL_W  = 32;
	localparam int REST_W = 34;
	localparam int DIFF_W = 35;
	localparam int QUAD_N = 4;

endpackage

// ----- rtl/fsq_store.sv -----
`timescale 1ns / 1ps
module fsq_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic signed [fsq_pkg::VAL_W-1:0] wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic signed [fsq_pkg::VAL_W-1:0] rd_data
);
	import fsq_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/fsq_alu.sv -----
`timescale 1ns / 1ps
module fsq_alu (
	input  logic signed [fsq_pkg::VAL_W-1:0]  x,
	input  logic signed [fsq_pkg::VAL_W-1:0]  y,
	input  logic signed [fsq_pkg::REST_W-1:0] ref_val,
	output logic signed [fsq_pkg::DIFF_W-1:0] diff,
	output fsq_pkg::alu_flag_t                flag
);
	import fsq_pkg::*;

	logic signed [VAL_W:0] sum;

	// full-width sum and difference: never wraps
	assign sum  = {x[VAL_W-1], x} + {y[VAL_W-1], y};
	assign diff = {ref_val[REST_W-1], ref_val} - {{(DIFF_W-VAL_W-1){sum[VAL_W]}}, sum};
	assign flag.neg  = diff[DIFF_W-1];
	assign flag.zero = (diff == '0);

endmodule

// ----- rtl/fsq_seq.sv -----
`timescale 1ns / 1ps
module fsq_seq #(
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_RESULTS  = 64,
	parameter int AW           = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic signed [fsq_pkg::VAL_W-1:0]  target_sum,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [fsq_pkg::VAL_W-1:0]  value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fsq_pkg::VAL_W-1:0]  first_value,
	output logic signed [fsq_pkg::VAL_W-1:0]  second_value,
	output logic signed [fsq_pkg::VAL_W-1:0]  third_value,
	output logic signed [fsq_pkg::VAL_W-1:0]  fourth_value,
	output logic                              found,
	output logic                              final_res,
	output logic                              overflowed,
	output logic                              wr_en,
	output logic [AW-1:0]                     wr_addr,
	output logic signed [fsq_pkg::VAL_W-1:0]  wr_data,
	output logic [AW-1:0]                     rd_addr,
	input  logic signed [fsq_pkg::VAL_W-1:0]  rd_data,
	output logic signed [fsq_pkg::VAL_W-1:0]  alu_x,
	output logic signed [fsq_pkg::VAL_W-1:0]  alu_y,
	output logic signed [fsq_pkg::REST_W-1:0] alu_ref,
	input  logic signed [fsq_pkg::DIFF_W-1:0] alu_diff,
	input  fsq_pkg::alu_flag_t                alu_flag
);
	import fsq_pkg::*;

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int RW = $clog2(MAX_RESULTS + 2);

	state_t state_q, state_d;
	pass_t  pass_q;

	logic signed [VAL_W-1:0] tgt_q;
	logic [CW-1:0] count_q, n_q, i_q, j_q, lo_q, hi_q;
	logic dropped_q, over_q, then_hi_q;
	logic [RW-1:0] total_q, emit_q;
	logic signed [VAL_W-1:0] key_q, vi_q, vj_q, va_q, vb_q;
	logic signed [REST_W-1:0] rest_q;
	logic out_valid_q, found_q, final_q, over_out_q;
	logic signed [VAL_W-1:0] q0_q, q1_q, q2_q, q3_q;

	logic [CW-1:0] rd_idx, wr_idx, lo_inc, hi_dec, j_inc, i_inc, count_inc;
	logic in_acc, full, out_free, out_load, last_emit, total_over;
	logic [RW-1:0] total_inc, emit_inc, nres;

	assign in_acc    = in_valid && !in_stall;
	assign full      = (count_q == CW'(MAX_ELEMENTS));
	assign count_inc = full ? count_q : count_q + CW'(1);
	assign lo_inc    = lo_q + CW'(1);
	assign hi_dec    = hi_q - CW'(1);
	assign j_inc     = j_q + CW'(1);
	assign i_inc     = i_q + CW'(1);
	assign total_inc = total_q + RW'(1);
	assign emit_inc  = emit_q + RW'(1);
	assign total_over = (total_q > RW'(MAX_RESULTS));
	assign nres      = total_over ? RW'(MAX_RESULTS) : total_q;
	assign last_emit = (emit_inc == nres);
	assign out_free  = !out_valid_q || !out_stall;

	assign rd_addr = rd_idx[AW-1:0];
	assign wr_addr = wr_idx[AW-1:0];

	always_comb begin
		alu_x   = va_q;
		alu_y   = vb_q;
		alu_ref = rest_q;
		case (state_q)
			ST_SORT_CMP: begin
				alu_x   = rd_data;
				alu_y   = '0;
				alu_ref = {{(REST_W-VAL_W){key_q[VAL_W-1]}}, key_q};
			end
			ST_J_GOT: begin
				alu_x   = vi_q;
				alu_y   = rd_data;
				alu_ref = {{(REST_W-VAL_W){tgt_q[VAL_W-1]}}, tgt_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		rd_idx   = i_q;
		wr_en    = 1'b0;
		wr_idx   = j_q;
		wr_data  = key_q;
		out_load = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				wr_idx   = count_q;
				wr_data  = value;
				wr_en    = in_acc && !full;
				if (in_acc && last) begin
					state_d = (count_inc >= CW'(QUAD_N)) ? ST_SORT_I : ST_MARK;
				end
			end
			ST_SORT_I: begin
				state_d = (i_q >= n_q) ? ST_I_CHK : ST_SORT_KEY;
			end
			ST_SORT_KEY: state_d = ST_SORT_CHK;
			ST_SORT_CHK: begin
				rd_idx = j_q - CW'(1);
				if (j_q == '0) begin
					wr_en   = 1'b1;
					state_d = ST_SORT_I;
				end else begin
					state_d = ST_SORT_CMP;
				end
			end
			ST_SORT_CMP: begin
				wr_en = 1'b1;
				if (alu_flag.neg) begin
					wr_data = rd_data;
					state_d = ST_SORT_CHK;
				end else begin
					state_d = ST_SORT_I;
				end
			end
			ST_I_CHK: state_d = (i_q >= n_q) ? ST_PASS_END : ST_I_GOT;
			ST_I_GOT: state_d = ST_J_CHK;
			ST_J_CHK: begin
				rd_idx  = j_q;
				state_d = (j_q >= n_q) ? ST_IS_STEP : ST_J_GOT;
			end
			ST_J_GOT: state_d = ST_P_START;
			ST_P_START: begin
				rd_idx  = lo_q;
				state_d = (lo_q < hi_q) ? ST_P_A : ST_JS_STEP;
			end
			ST_P_A: begin
				rd_idx  = hi_q;
				state_d = ST_P_B;
			end
			ST_P_B: state_d = ST_EVAL;
			ST_EVAL: begin
				if (alu_flag.zero) begin
					state_d = ST_MATCH;
				end else if (alu_flag.neg) begin
					state_d = ST_HI_STEP;
				end else begin
					state_d = ST_LO_STEP;
				end
			end
			ST_MATCH: begin
				if (pass_q == PASS_COUNT) begin
					state_d = (total_inc > RW'(MAX_RESULTS)) ? ST_PASS_END : ST_LO_STEP;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = last_emit ? ST_IDLE : ST_LO_STEP;
				end
			end
			ST_LO_STEP: begin
				rd_idx  = lo_inc;
				state_d = (lo_inc < hi_q) ? ST_LO_GOT : ST_JS_STEP;
			end
			ST_LO_GOT: begin
				if (rd_data == va_q) begin
					state_d = ST_LO_STEP;
				end else begin
					state_d = then_hi_q ? ST_HI_STEP : ST_EVAL;
				end
			end
			ST_HI_STEP: begin
				rd_idx  = hi_dec;
				state_d = (lo_q < hi_dec) ? ST_HI_GOT : ST_JS_STEP;
			end
			ST_HI_GOT: state_d = (rd_data == vb_q) ? ST_HI_STEP : ST_EVAL;
			ST_JS_STEP: begin
				rd_idx  = j_inc;
				state_d = (j_inc < n_q) ? ST_JS_GOT : ST_J_CHK;
			end
			ST_JS_GOT: state_d = (rd_data == vj_q) ? ST_JS_STEP : ST_J_CHK;
			ST_IS_STEP: begin
				rd_idx  = i_inc;
				state_d = (i_inc < n_q) ? ST_IS_GOT : ST_I_CHK;
			end
			ST_IS_GOT: state_d = (rd_data == vi_q) ? ST_IS_STEP : ST_I_CHK;
			ST_PASS_END: begin
				if (pass_q == PASS_COUNT && total_q != '0) begin
					state_d = ST_I_CHK;
				end else if (pass_q == PASS_COUNT) begin
					state_d = ST_MARK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MARK: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PASS_COUNT;
			tgt_q       <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			over_q      <= 1'b0;
			total_q     <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				tgt_q <= target_sum;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (last) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							over_q    <= dropped_q || full;
							pass_q    <= PASS_COUNT;
							total_q   <= '0;
							emit_q    <= '0;
						end else begin
							count_q   <= count_inc;
							dropped_q <= dropped_q || full;
						end
					end
				end
				ST_MATCH: begin
					if (pass_q == PASS_COUNT) begin
						total_q <= total_inc;
					end else if (out_free) begin
						emit_q <= emit_inc;
					end
				end
				ST_PASS_END: begin
					over_q <= over_q || total_over;
					pass_q <= PASS_EMIT;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= count_inc;
				i_q <= CW'(1);
			end
			ST_SORT_KEY: begin
				key_q <= rd_data;
				j_q   <= i_q;
			end
			ST_SORT_CHK: begin
				if (j_q == '0) begin
					i_q <= i_inc;
				end
			end
			ST_SORT_CMP: begin
				if (alu_flag.neg) begin
					j_q <= j_q - CW'(1);
				end else begin
					i_q <= i_inc;
				end
			end
			ST_SORT_I: begin
				if (i_q >= n_q) begin
					i_q <= '0;
				end
			end
			ST_I_GOT: begin
				vi_q <= rd_data;
				j_q  <= i_inc;
			end
			ST_J_GOT: begin
				vj_q   <= rd_data;
				rest_q <= alu_diff[REST_W-1:0];
				lo_q   <= j_inc;
				hi_q   <= n_q - CW'(1);
			end
			ST_P_A: va_q <= rd_data;
			ST_P_B: vb_q <= rd_data;
			ST_EVAL: then_hi_q <= 1'b0;
			ST_MATCH: begin
				then_hi_q <= 1'b1;
				if (out_free) begin
					q0_q       <= vi_q;
					q1_q       <= vj_q;
					q2_q       <= va_q;
					q3_q       <= vb_q;
					found_q    <= 1'b1;
					final_q    <= last_emit;
					over_out_q <= over_q;
				end
			end
			ST_LO_STEP: lo_q <= lo_inc;
			ST_LO_GOT: begin
				if (rd_data != va_q) begin
					va_q <= rd_data;
				end
			end
			ST_HI_STEP: hi_q <= hi_dec;
			ST_HI_GOT: begin
				if (rd_data != vb_q) begin
					vb_q <= rd_data;
				end
			end
			ST_JS_STEP: j_q <= j_inc;
			ST_IS_STEP: i_q <= i_inc;
			ST_PASS_END: i_q <= '0;
			ST_MARK: begin
				if (out_free) begin
					q0_q       <= '0;
					q1_q       <= '0;
					q2_q       <= '0;
					q3_q       <= '0;
					found_q    <= 1'b0;
					final_q    <= 1'b1;
					over_out_q <= over_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign first_value  = q0_q;
	assign second_value = q1_q;
	assign third_value  = q2_q;
	assign fourth_value = q3_q;
	assign found        = found_q;
	assign final_res    = final_q;
	assign overflowed   = over_out_q;

endmodule

// ----- rtl/four_sum_unique_quadruples_top.sv -----
`timescale 1ns / 1ps
// Four-sum search. Elements load at one beat per cycle into an internal store; the beat marked
// last closes the set and the input stalls until the set is done. A set of four or more
// is then sorted in place by insertion sort and searched by the two-pointer method: a
// counting pass, then, if that found results, an emitting pass that stops after the last
// result; otherwise a none-found marker goes out. Every element comes through the single
// registered read port of the store and every sum goes through one shared adder and
// comparator. Results wait in an output register, so the search holds only while it is
// full. Elements past MAX_ELEMENTS are dropped and results past MAX_RESULTS are cut;
// either sets overflowed on every result of the set.
module four_sum_unique_quadruples_top #(
	parameter int MAX_ELEMENTS = 64,
	parameter int MAX_RESULTS  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic signed [fsq_pkg::VAL_W-1:0] target_sum,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [fsq_pkg::VAL_W-1:0] value,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [fsq_pkg::VAL_W-1:0] first_value,
	output logic signed [fsq_pkg::VAL_W-1:0] second_value,
	output logic signed [fsq_pkg::VAL_W-1:0] third_value,
	output logic signed [fsq_pkg::VAL_W-1:0] fourth_value,
	output logic                             found,
	output logic                             final_res,
	output logic                             overflowed
);
	import fsq_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);

	logic                     wr_en;
	logic [AW-1:0]            wr_addr, rd_addr;
	logic signed [VAL_W-1:0]  wr_data, rd_data, alu_x, alu_y;
	logic signed [REST_W-1:0] alu_ref;
	logic signed [DIFF_W-1:0] alu_diff;
	alu_flag_t                alu_flag;

	fsq_store #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	fsq_alu u_alu (
		.x(alu_x), .y(alu_y), .ref_val(alu_ref), .diff(alu_diff), .flag(alu_flag)
	);

	fsq_seq #(.MAX_ELEMENTS(MAX_ELEMENTS), .MAX_RESULTS(MAX_RESULTS), .AW(AW)) u_seq (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .target_sum(target_sum),
		.in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.first_value(first_value), .second_value(second_value),
		.third_value(third_value), .fourth_value(fourth_value),
		.found(found), .final_res(final_res), .overflowed(overflowed),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data),
		.alu_x(alu_x), .alu_y(alu_y), .alu_ref(alu_ref),
		.alu_diff(alu_diff), .alu_flag(alu_flag)
	);

endmodule

// ----- rtl/fsq_checker.sv -----
`timescale 1ns / 1ps
module fsq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             last,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [fsq_pkg::VAL_W-1:0] first_value,
	input logic signed [fsq_pkg::VAL_W-1:0] second_value,
	input logic signed [fsq_pkg::VAL_W-1:0] third_value,
	input logic signed [fsq_pkg::VAL_W-1:0] fourth_value,
	input logic                             found,
	input logic                             final_res
);
	import fsq_pkg::*;

	// closing beat starts the search, so input must stall
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> in_stall)
		else $error("input not stalled after closing beat");

	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !last) |=> !in_stall)
		else $error("input stalled during loading");

	a_marker_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> final_res)
		else $error("none-found marker is not final");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (first_value == '0 && second_value == '0 &&
			third_value == '0 && fourth_value == '0))
		else $error("none-found marker carries values");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(first_value) &&
			$stable(fourth_value)))
		else $error("stalled result changed");

endmodule

bind four_sum_unique_quadruples_top fsq_checker u_fsq_checker (.*);
